>>> rtl/spm_pkg.sv
`timescale 1ns / 1ps

package spm_pkg;

    // Result field widths (signed fixed point, 16 fraction bits)
    localparam int VI_BITS         = 37;
    localparam int P_BITS          = 57;

    // Gain format and fraction bits dropped after each product
    localparam int GAIN_BITS       = 32;
    localparam int GAIN_FRAC_DROP  = 8;
    localparam int POWER_FRAC_DROP = 16;

    // Result bus layout
    localparam int OUT_BITS        = 2 * VI_BITS + P_BITS;
    localparam int OUT_TDATA_BITS  = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS    = OUT_TDATA_BITS - OUT_BITS;

    // Configuration port
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 32;

    localparam logic [GAIN_BITS-1:0] VOLTAGE_GAIN_RST = 32'd1638400;
    localparam logic [GAIN_BITS-1:0] CURRENT_GAIN_RST = 32'd1228800;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_VOLTAGE_OFFSET = 2'd0,
        REG_CURRENT_OFFSET = 2'd1,
        REG_VOLTAGE_GAIN   = 2'd2,
        REG_CURRENT_GAIN   = 2'd3
    } cfg_index_t;

    // Gains handed from the register file to the arithmetic unit
    typedef struct packed {
        logic [GAIN_BITS-1:0] voltage_gain;
        logic [GAIN_BITS-1:0] current_gain;
    } gain_cfg_t;

endpackage

>>> rtl/spm_queue.sv
`timescale 1ns / 1ps

module spm_queue
    import spm_pkg::*;
#(
    parameter int W = 26
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         pop_valid,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         do_push;
    logic         do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Store a pushed request
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> rtl/spm_front.sv
`timescale 1ns / 1ps

module spm_front
    import spm_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [2*SAMPLE_BITS-1:0]       sample_pair,
    input  logic [SAMPLE_BITS-1:0]         voltage_offset,
    input  logic [SAMPLE_BITS-1:0]         current_offset,
    input  logic                           q_full,
    output logic                           q_push,
    output logic [2*(SAMPLE_BITS+1)-1:0]   q_data
);

    localparam int FW = SAMPLE_BITS + 1;

    logic [SAMPLE_BITS-1:0] voltage_sample;
    logic [SAMPLE_BITS-1:0] current_sample;
    logic signed [FW-1:0]   voltage_diff;
    logic signed [FW-1:0]   current_diff;

    assign voltage_sample = sample_pair[SAMPLE_BITS-1:0];
    assign current_sample = sample_pair[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // Remove the zero offsets; the difference always fits one extra sign bit
    assign voltage_diff = $signed({1'b0, voltage_sample}) - $signed({1'b0, voltage_offset});
    assign current_diff = $signed({1'b0, current_sample}) - $signed({1'b0, current_offset});

    // Accept whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign q_data   = {current_diff, voltage_diff};

endmodule

>>> rtl/spm_back.sv
`timescale 1ns / 1ps

module spm_back
    import spm_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gain_cfg_t                     gains,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  logic [2*(SAMPLE_BITS+1)-1:0]  q_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VI_BITS-1:0]     voltage_value,
    output logic signed [VI_BITS-1:0]     current_value,
    output logic signed [P_BITS-1:0]      power_value
);

    // Filter value, filter sum and its magnitude
    localparam int FW = SAMPLE_BITS + 1;
    localparam int SW = SAMPLE_BITS + 4;
    localparam int MW = SAMPLE_BITS + 3;
    // Reciprocal of 7 scaled by 2^MW; quotient is exact or one short
    localparam logic [MW-1:0] DIV_RECIP = MW'((2 ** MW) / 7);
    // Gain product: natural width, and a width that covers the output slice
    localparam int GNW = FW + GAIN_BITS + 1;
    localparam int GW  = (GNW > VI_BITS + GAIN_FRAC_DROP) ? GNW : VI_BITS + GAIN_FRAC_DROP;
    // Full scaled value and the split for the power partial products
    localparam int VW  = FW + GAIN_BITS - GAIN_FRAC_DROP;
    localparam int H   = (VW + 1) / 2;
    localparam int PW  = (2 * VW > P_BITS + POWER_FRAC_DROP) ?
                         2 * VW : P_BITS + POWER_FRAC_DROP;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIX,
        ST_GAIN,
        ST_PA,
        ST_PB,
        ST_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic signed [FW-1:0]     filt_reg [2];
    logic signed [FW-1:0]     filt_next [2];
    logic                     neg_reg [2];
    logic                     neg_next [2];
    logic [MW-1:0]            mag_reg [2];
    logic [MW-1:0]            mag_next [2];
    logic [MW-1:0]            q0_reg [2];
    logic [MW-1:0]            q0_next [2];
    logic signed [VW-1:0]     full_reg [2];
    logic signed [VW-1:0]     full_next [2];
    logic signed [VI_BITS-1:0] vi_reg [2];
    logic signed [VI_BITS-1:0] vi_next [2];
    logic signed [PW-1:0]     pa_reg, pa_next;
    logic signed [PW-1:0]     pb_reg, pb_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [VI_BITS-1:0] volt_out_reg, volt_out_next;
    logic signed [VI_BITS-1:0] amp_out_reg, amp_out_next;
    logic signed [P_BITS-1:0] pwr_out_reg, pwr_out_next;

    // Per-lane combinational terms (lane 0 voltage, lane 1 current)
    logic signed [FW-1:0]     diff [2];
    logic signed [SW-1:0]     sum [2];
    logic signed [SW-1:0]     sum_abs [2];
    logic [2*MW-1:0]          recip_prod [2];
    logic [MW-1:0]            rem [2];
    logic [MW-1:0]            quot [2];
    logic [GAIN_BITS-1:0]     lane_gain [2];
    logic signed [GNW-1:0]    gain_prod [2];
    logic signed [GW-1:0]     gain_ext [2];

    // Power partial products
    logic [H-1:0]             v_lo, a_lo;
    logic signed [VW-H-1:0]   v_hi, a_hi;
    logic signed [VW:0]       pp_hl;
    logic signed [2*H+1:0]    pp_ll;
    logic signed [2*(VW-H)-1:0] pp_hh;
    logic signed [VW:0]       pp_lh;
    logic signed [PW-1:0]     power_full;
    logic                     out_free;

    assign lane_gain[0] = gains.voltage_gain;
    assign lane_gain[1] = gains.current_gain;

    assign v_lo = full_reg[0][H-1:0];
    assign v_hi = full_reg[0][VW-1:H];
    assign a_lo = full_reg[1][H-1:0];
    assign a_hi = full_reg[1][VW-1:H];

    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    // Filter, gain, power products and sequencing
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        volt_out_next  = volt_out_reg;
        amp_out_next   = amp_out_reg;
        pwr_out_next   = pwr_out_reg;

        // Partial products of voltage times current
        pp_hl = $signed(v_hi) * $signed({1'b0, a_lo});
        pp_ll = $signed({1'b0, v_lo}) * $signed({1'b0, a_lo});
        pp_hh = $signed(v_hi) * $signed(a_hi);
        pp_lh = $signed({1'b0, v_lo}) * $signed(a_hi);
        power_full = (pb_reg <<< H) + pa_reg;

        for (int c = 0; c < 2; c++) begin
            filt_next[c] = filt_reg[c];
            neg_next[c]  = neg_reg[c];
            mag_next[c]  = mag_reg[c];
            q0_next[c]   = q0_reg[c];
            full_next[c] = full_reg[c];
            vi_next[c]   = vi_reg[c];

            // 3*previous + 4*difference, then magnitude times 1/7
            diff[c]       = $signed(q_data[c*FW +: FW]);
            sum[c]        = (SW'(filt_reg[c]) <<< 1) + SW'(filt_reg[c]) + (SW'(diff[c]) <<< 2);
            sum_abs[c]    = sum[c][SW-1] ? -sum[c] : sum[c];
            recip_prod[c] = {{MW{1'b0}}, sum_abs[c][MW-1:0]} * {{MW{1'b0}}, DIV_RECIP};

            // Correct the estimate by one where the remainder reaches 7
            rem[c]  = mag_reg[c] - (MW'({q0_reg[c], 3'b000}) - q0_reg[c]);
            quot[c] = (rem[c] >= MW'(7)) ? q0_reg[c] + MW'(1) : q0_reg[c];

            // Filtered value times unsigned gain, floor drop of fraction bits
            gain_prod[c] = $signed(filt_reg[c]) * $signed({1'b0, lane_gain[c]});
            gain_ext[c]  = GW'(gain_prod[c]);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    for (int c = 0; c < 2; c++) begin
                        neg_next[c] = sum[c][SW-1];
                        mag_next[c] = sum_abs[c][MW-1:0];
                        q0_next[c]  = recip_prod[c][2*MW-1:MW];
                    end
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                for (int c = 0; c < 2; c++) begin
                    filt_next[c] = neg_reg[c] ? -FW'(quot[c]) : FW'(quot[c]);
                end
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                for (int c = 0; c < 2; c++) begin
                    full_next[c] = gain_ext[c][VW+GAIN_FRAC_DROP-1:GAIN_FRAC_DROP];
                    vi_next[c]   = gain_ext[c][VI_BITS+GAIN_FRAC_DROP-1:GAIN_FRAC_DROP];
                end
                state_next = ST_PA;
            end
            ST_PA: begin
                pa_next    = (PW'(pp_hl) <<< H) + PW'(pp_ll);
                state_next = ST_PB;
            end
            ST_PB: begin
                pb_next    = (PW'(pp_hh) <<< H) + PW'(pp_lh);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (out_free) begin
                    volt_out_next = vi_reg[0];
                    amp_out_next  = vi_reg[1];
                    pwr_out_next  = power_full[P_BITS+POWER_FRAC_DROP-1:POWER_FRAC_DROP];
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Output register: drop on take, load on completion
        if (state_reg == ST_OUT && out_free) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 2; c++) begin
            neg_reg[c]  <= neg_next[c];
            mag_reg[c]  <= mag_next[c];
            q0_reg[c]   <= q0_next[c];
            full_reg[c] <= full_next[c];
            vi_reg[c]   <= vi_next[c];
        end
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        volt_out_reg <= volt_out_next;
        amp_out_reg  <= amp_out_next;
        pwr_out_reg  <= pwr_out_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                filt_reg[c] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            for (int c = 0; c < 2; c++) begin
                filt_reg[c] <= filt_next[c];
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign voltage_value = volt_out_reg;
    assign current_value = amp_out_reg;
    assign power_value   = pwr_out_reg;

endmodule

>>> rtl/smoothed_power_meter_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tdata: voltage_sample, current_sample
// m_        out        m_tvalid / m_tready  m_tdata: voltage_value, current_value, power_value
// cfg_      in         cfg_we               cfg_index, cfg_wdata (no read-back)
//
// The arithmetic unit takes one sample pair at a time from the queue to the
// output register (divide-by-7 estimate and fix, gain multiply, two power
// partial-product steps, output load).
// A two-entry queue takes new pairs while the arithmetic unit is busy or the
// output waits to be taken. Reset is synchronous, active low, and clears the
// filter state and the registers to their defaults.

module smoothed_power_meter_unit
    import spm_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // voltage_sample, current_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // voltage_value, current_value, power_value, zero fill
    output logic [OUT_TDATA_BITS-1:0]               m_tdata,
    input  logic                                    cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0]                cfg_wdata
);

    localparam int QW = 2 * (SAMPLE_BITS + 1);

    logic [SAMPLE_BITS-1:0]     voltage_offset_reg;
    logic [SAMPLE_BITS-1:0]     current_offset_reg;
    gain_cfg_t                  gains_reg;
    logic                       q_full;
    logic                       q_push;
    logic [QW-1:0]              q_push_data;
    logic                       q_pop;
    logic                       q_valid;
    logic [QW-1:0]              q_pop_data;
    logic signed [VI_BITS-1:0]  voltage_value;
    logic signed [VI_BITS-1:0]  current_value;
    logic signed [P_BITS-1:0]   power_value;

    // Register file writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voltage_offset_reg      <= '0;
            current_offset_reg      <= '0;
            gains_reg.voltage_gain  <= VOLTAGE_GAIN_RST;
            gains_reg.current_gain  <= CURRENT_GAIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_VOLTAGE_OFFSET: voltage_offset_reg     <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_CURRENT_OFFSET: current_offset_reg     <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_VOLTAGE_GAIN:   gains_reg.voltage_gain <= cfg_wdata[GAIN_BITS-1:0];
                REG_CURRENT_GAIN:   gains_reg.current_gain <= cfg_wdata[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    spm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .sample_pair    (s_tdata[2*SAMPLE_BITS-1:0]),
        .voltage_offset (voltage_offset_reg),
        .current_offset (current_offset_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_push_data)
    );

    spm_queue #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_pop_data)
    );

    spm_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .gains         (gains_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_data        (q_pop_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .voltage_value (voltage_value),
        .current_value (current_value),
        .power_value   (power_value)
    );

    // Pack the result request
    assign m_tdata = {{OUT_PAD_BITS{1'b0}}, power_value, current_value, voltage_value};

endmodule
